@@ rtl/core/usb_host_register_file_unit_assert.svh @@
// Assertion macros used by the register file RTL.
`ifndef USB_HOST_REGISTER_FILE_UNIT_ASSERT_SVH
`define USB_HOST_REGISTER_FILE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define UHRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define UHRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/uhrf_pkg.sv @@
// Types, register offsets and field masks of the host controller register window.
package uhrf_pkg;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_PRELOAD = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_RUN         = 3'd1,
    EV_STOP        = 3'd2,
    EV_HOST_RESET  = 3'd3,
    EV_PORT_RESET  = 3'd4,
    EV_INTR_ENABLE = 3'd5,
    EV_CMD_DB      = 3'd6,
    EV_XFER_DB     = 3'd7
  } event_code_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_WR2  = 2'd2
  } uhrf_state_t;

  typedef struct packed {
    event_code_t code;
    logic [7:0]  index;
    logic [7:0]  endpoint;
    logic [15:0] stream;
  } uhrf_event_t;

  // Store updates and events worked out for one transaction.
  typedef struct packed {
    logic        wr0_en;
    logic [31:0] wr0_data;
    logic        wr1_en;
    logic [31:0] wr1_data;
    logic [1:0]  ev_cnt;
    uhrf_event_t ev0;
    uhrf_event_t ev1;
  } uhrf_action_t;

  typedef struct packed {
    logic [63:0] read_data;
    uhrf_event_t ev;
    logic        last;
  } uhrf_result_t;

  localparam logic [15:0] OFF_USBCMD    = 16'h0080;
  localparam logic [15:0] OFF_USBSTS    = 16'h0084;
  localparam logic [15:0] OFF_DNCTRL    = 16'h0094;
  localparam logic [15:0] OFF_CRCR_LO   = 16'h0098;
  localparam logic [15:0] OFF_CRCR_HI   = 16'h009C;
  localparam logic [15:0] OFF_DCBAAP_LO = 16'h00B0;
  localparam logic [15:0] OFF_DCBAAP_HI = 16'h00B4;
  localparam logic [15:0] OFF_PORT_BASE = 16'h0480;
  localparam logic [15:0] OFF_PORT_END  = 16'h0500;
  localparam logic [15:0] OFF_INTR_BASE = 16'h2020;
  localparam logic [15:0] OFF_INTR_END  = 16'h2120;
  localparam logic [15:0] OFF_DB_BASE   = 16'h3000;
  localparam logic [15:0] OFF_DB_END    = 16'h3400;
  localparam logic [15:0] OFF_EXT_BASE  = 16'h8000;
  localparam logic [15:0] OFF_EXT_END   = 16'h8380;

  localparam logic [31:0] CP_USBCMD     = 32'h0001EF8C;
  localparam logic [31:0] W1C_USBSTS    = 32'h0000041C;
  localparam logic [31:0] CP_LOW16      = 32'h0000FFFF;
  localparam logic [31:0] CP_CRCR       = 32'hFFFFFFC1;
  localparam logic [31:0] W1S_CRCR      = 32'h00000006;
  localparam logic [31:0] CP_PTR64      = 32'hFFFFFFC0;
  localparam logic [31:0] CP_PORTSC     = 32'h0E01C3E0;
  localparam logic [31:0] W1C_PORTSC    = 32'h00FE0002;
  localparam logic [31:0] W1S_PORTSC    = 32'h80000010;
  localparam logic [31:0] CP_PORTPM_LO  = 32'hF001FFF8;
  localparam logic [31:0] CP_PORTPM_HI  = 32'h0001FFFF;
  localparam logic [31:0] CP_PORTHLPMC  = 32'h00003FFF;
  localparam logic [31:0] CP_IMAN       = 32'h00000002;
  localparam logic [31:0] W1C_IMAN      = 32'h00000001;

  function automatic logic [31:0] uhrf_merge(input logic [31:0] old, input logic [31:0] nv,
                                             input logic [31:0] cp, input logic [31:0] w1c,
                                             input logic [31:0] w1s);
    logic [31:0] r;
    r = (old & ~cp) | (nv & cp);
    r = r & ~(nv & w1c);
    r = r | (nv & w1s);
    return r;
  endfunction

endpackage

@@ rtl/core/uhrf_channels.sv @@
// Request and result channel interfaces of the register window.
interface uhrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] byte_offset;
  logic        wide_access;
  logic [63:0] write_data;

  modport source (output valid, req_type, byte_offset, wide_access, write_data, input ready);
  modport sink   (input valid, req_type, byte_offset, wide_access, write_data, output ready);
endinterface

interface uhrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [2:0]  event_code;
  logic [7:0]  event_index;
  logic [7:0]  endpoint_id;
  logic [15:0] stream_num;
  logic        last_result;

  modport source (output valid, read_data, event_code, event_index, endpoint_id, stream_num,
                  last_result, input ready);
  modport sink   (input valid, read_data, event_code, event_index, endpoint_id, stream_num,
                  last_result, output ready);
endinterface

@@ rtl/core/uhrf_decode.sv @@
// Offset decode, field merge and event generation for one register transaction.
module uhrf_decode (
  input  uhrf_pkg::req_type_t    req_type,
  input  logic [13:0]            word,
  input  logic                   wide,
  input  logic [63:0]            data,
  input  logic [31:0]            old,
  output uhrf_pkg::uhrf_action_t act
);
  import uhrf_pkg::*;

  logic [15:0] off;
  logic [15:0] intr_rel;
  logic [31:0] lo;
  logic [31:0] hi;

  assign off      = {word, 2'b00};
  assign intr_rel = off - OFF_INTR_BASE;
  assign lo       = data[31:0];
  assign hi       = data[63:32];

  always_comb begin
    act          = '0;
    act.wr1_data = hi;
    case (req_type)
      REQ_PRELOAD: begin
        act.wr0_en   = 1'b1;
        act.wr0_data = lo;
        act.wr1_en   = wide;
      end
      REQ_WRITE: begin
        if (!wide) begin
          if (off == OFF_USBCMD) begin
            // Run/stop edge first, then host reset, in one or two results.
            if (!old[0] && lo[0]) begin
              act.ev0.code = EV_RUN;
              act.ev_cnt   = 2'd1;
            end else if (old[0] && !lo[0]) begin
              act.ev0.code = EV_STOP;
              act.ev_cnt   = 2'd1;
            end
            if (!old[1] && lo[1]) begin
              if (act.ev_cnt == 2'd0) begin
                act.ev0.code = EV_HOST_RESET;
                act.ev_cnt   = 2'd1;
              end else begin
                act.ev1.code = EV_HOST_RESET;
                act.ev_cnt   = 2'd2;
              end
            end
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_USBCMD, '0, '0);
          end else if (off == OFF_USBSTS) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, '0, W1C_USBSTS, '0);
          end else if (off == OFF_DNCTRL) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_LOW16, '0, '0);
          end else if (off == OFF_CRCR_LO) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_CRCR, '0, W1S_CRCR);
          end else if (off == OFF_CRCR_HI || off == OFF_DCBAAP_HI) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = lo;
          end else if (off == OFF_DCBAAP_LO) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_PTR64, '0, '0);
          end else if (off >= OFF_PORT_BASE && off < OFF_PORT_END) begin
            // Four words per port: status/control, power management, link info, LPM.
            act.wr0_en = 1'b1;
            case (off[3:2])
              2'd0: begin
                if (lo[4]) begin
                  act.ev0.code  = EV_PORT_RESET;
                  act.ev0.index = {5'd0, off[6:4]};
                  act.ev_cnt    = 2'd1;
                end
                act.wr0_data = uhrf_merge(old, lo, CP_PORTSC, W1C_PORTSC, W1S_PORTSC);
              end
              2'd1: act.wr0_data = uhrf_merge(old, lo, off[6] ? CP_PORTPM_HI : CP_PORTPM_LO,
                                              '0, '0);
              2'd2: act.wr0_data = uhrf_merge(old, lo, CP_LOW16, '0, '0);
              default: act.wr0_data = uhrf_merge(old, lo, CP_PORTHLPMC, '0, '0);
            endcase
          end else if (off >= OFF_INTR_BASE && off < OFF_INTR_END) begin
            // Eight words per interrupter; the reserved word is left alone.
            case (intr_rel[4:2])
              3'd0: begin
                if (!old[1] && lo[1]) begin
                  act.ev0.code  = EV_INTR_ENABLE;
                  act.ev0.index = {5'd0, intr_rel[7:5]};
                  act.ev_cnt    = 2'd1;
                end
                act.wr0_en   = 1'b1;
                act.wr0_data = uhrf_merge(old, lo, CP_IMAN, W1C_IMAN, '0);
              end
              3'd2: begin
                act.wr0_en   = 1'b1;
                act.wr0_data = uhrf_merge(old, lo, CP_LOW16, '0, '0);
              end
              3'd3: act.wr0_en = 1'b0;
              3'd4, 3'd6: begin
                act.wr0_en   = 1'b1;
                act.wr0_data = uhrf_merge(old, lo, CP_PTR64, '0, '0);
              end
              default: begin
                act.wr0_en   = 1'b1;
                act.wr0_data = lo;
              end
            endcase
          end else if (off == OFF_DB_BASE) begin
            act.ev0.code = EV_CMD_DB;
            act.ev_cnt   = 2'd1;
          end else if (off > OFF_DB_BASE && off < OFF_DB_END) begin
            act.ev0.code     = EV_XFER_DB;
            act.ev0.index    = off[9:2];
            act.ev0.endpoint = lo[7:0];
            act.ev0.stream   = lo[31:16];
            act.ev_cnt       = 2'd1;
          end else if (off >= OFF_EXT_BASE && off < OFF_EXT_END) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = lo;
          end
        end else begin
          // 64-bit registers only: the upper word is copied whole.
          if (off == OFF_CRCR_LO) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_CRCR, '0, W1S_CRCR);
          end else if (off == OFF_DCBAAP_LO) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_PTR64, '0, '0);
          end else if (off >= OFF_INTR_BASE && off < OFF_INTR_END &&
                       (intr_rel[4:2] == 3'd4 || intr_rel[4:2] == 3'd6)) begin
            act.wr0_en   = 1'b1;
            act.wr0_data = uhrf_merge(old, lo, CP_PTR64, '0, '0);
          end
          act.wr1_en = act.wr0_en;
        end
      end
      default: act = act;
    endcase
  end

endmodule

@@ rtl/core/usb_host_register_file_unit.sv @@
// Top level of the emulated USB host controller register window.
// The block serves bus transactions on the in_req channel (valid/ready) and returns one or
// two result transactions per request on the out_rsp channel (valid/ready). A request is a
// read, a masked register write or a raw preload of one 32-bit word, or of two words when
// wide_access is set. Masked writes keep the read-only bits of each decoded register, apply
// the write-1-to-clear and write-1-to-set fields and report run/stop, reset, interrupter
// enable and doorbell events; each event is its own result, and last_result marks the final
// result of a request. Writes to offsets that are not decoded leave the store unchanged.
// Timing: the request is taken in the idle state and the store is read at that edge. In
// ST_CALC, once the holding register is empty, the old word is merged with the write data,
// written back and the results are loaded. A second word (wide preload or wide write) is
// then written through the single write port in ST_WR2, before the return to idle.
// Back-pressure: results sit in a two-entry holding register. A new request is taken while
// results still wait, but its merge cycle holds until the holding register has drained.
// Accesses never overlap in the store, so no forwarding is needed.
// Reset clears the sequencer and the result count only; store contents are undefined until
// preloaded or written, and no clearing pass is run.
`include "usb_host_register_file_unit_assert.svh"

module usb_host_register_file_unit #(
  parameter int STORE_WORDS = 16384
) (
  input logic       clk,
  input logic       rst_n,
  uhrf_req_if.sink  in_req,
  uhrf_rsp_if.source out_rsp
);
  import uhrf_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [16:0] STORE_LIMIT = 17'(STORE_WORDS);

  logic [31:0]  store_mem [STORE_WORDS];
  logic [31:0]  rd0_r;
  logic [31:0]  rd1_r;

  uhrf_state_t  state_r, state_nxt;
  req_type_t    type_r;
  logic [13:0]  word_r;
  logic         wide_r;
  logic [63:0]  data_r;

  uhrf_result_t res0_r, res0_nxt;
  uhrf_result_t res1_r, res1_nxt;
  logic [1:0]   res_cnt_r, res_cnt_nxt;

  logic         in_fire;
  logic         out_fire;
  logic [16:0]  rwn0;
  logic [16:0]  rwn1;
  logic [16:0]  wn0;
  logic [16:0]  wn1;
  logic         in0;
  logic         in1;
  logic [31:0]  old_word;
  logic [63:0]  rdata;
  uhrf_action_t act;
  logic [1:0]   n_res;
  logic         mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]  mem_wdata;

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_fire = out_rsp.valid && out_rsp.ready;

  // Word numbers are widened beyond the 14-bit word field so that the word after the last
  // one can be recognised as lying outside it.
  assign rwn0 = {3'd0, in_req.byte_offset[15:2]};
  assign rwn1 = rwn0 + 17'd1;
  assign wn0  = {3'd0, word_r};
  assign wn1  = wn0 + 17'd1;
  assign in0  = wn0 < STORE_LIMIT;
  assign in1  = wn1 < STORE_LIMIT;

  // Both words are read when the request is taken; the read registers then hold until the
  // next request, which cannot arrive before the write-back has completed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd0_r <= store_mem[rwn0[AW-1:0]];
      rd1_r <= store_mem[rwn1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r <= req_type_t'(in_req.req_type);
      word_r <= in_req.byte_offset[15:2];
      wide_r <= in_req.wide_access;
      data_r <= in_req.write_data;
    end
  end

  assign old_word = in0 ? rd0_r : 32'd0;

  uhrf_decode u_decode (
    .req_type (type_r),
    .word     (word_r),
    .wide     (wide_r),
    .data     (data_r),
    .old      (old_word),
    .act      (act)
  );

  always_comb begin
    rdata = 64'd0;
    if (type_r == REQ_READ) begin
      rdata[31:0] = old_word;
      if (wide_r && in1) begin
        rdata[63:32] = rd1_r;
      end
    end
  end

  // A request with no event still returns a single result.
  assign n_res = (act.ev_cnt == 2'd0) ? 2'd1 : act.ev_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      res_cnt_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    res0_nxt     = res0_r;
    res1_nxt     = res1_r;
    res_cnt_nxt  = res_cnt_r;
    mem_we       = 1'b0;
    mem_waddr    = wn0[AW-1:0];
    mem_wdata    = act.wr0_data;
    in_req.ready = 1'b0;

    if (out_fire) begin
      res0_nxt    = res1_r;
      res_cnt_nxt = res_cnt_r - 2'd1;
    end

    case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // Results are loaded only into an empty holding register, so no output
        // transaction can coincide with the load.
        if (res_cnt_r == 2'd0) begin
          mem_we             = act.wr0_en && in0;
          res0_nxt.read_data = rdata;
          res0_nxt.ev        = act.ev0;
          res0_nxt.last      = (n_res == 2'd1);
          res1_nxt.read_data = 64'd0;
          res1_nxt.ev        = act.ev1;
          res1_nxt.last      = 1'b1;
          res_cnt_nxt        = n_res;
          state_nxt          = (act.wr1_en && in1) ? ST_WR2 : ST_IDLE;
        end
      end
      ST_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = wn1[AW-1:0];
        mem_wdata = act.wr1_data;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_rsp.valid       = res_cnt_r != 2'd0;
  assign out_rsp.read_data   = res0_r.read_data;
  assign out_rsp.event_code  = 3'(res0_r.ev.code);
  assign out_rsp.event_index = res0_r.ev.index;
  assign out_rsp.endpoint_id = res0_r.ev.endpoint;
  assign out_rsp.stream_num  = res0_r.ev.stream;
  assign out_rsp.last_result = res0_r.last;

  `UHRF_ASSERT_NEXT(a_calc_loads_results, clk, rst_n, state_r == ST_CALC && res_cnt_r == 2'd0, res_cnt_r != 2'd0, "merge cycle completed without loading a result")
  `UHRF_ASSERT_NOW(a_wr2_follows_calc, clk, rst_n, state_r == ST_WR2, $past(state_r) == ST_CALC, "second word written outside a merged request")
  `UHRF_ASSERT_NOW(a_last_matches_count, clk, rst_n, out_rsp.valid, out_rsp.last_result == (res_cnt_r == 2'd1), "last result flag disagrees with pending count")

endmodule

@@ tb/tb_usb_host_register_file_unit.sv @@
// Self-checking testbench for the USB host controller register window.
`timescale 1ns / 1ps

module tb_usb_host_register_file_unit;
  import uhrf_pkg::*;

  localparam int          WORDS       = 16384;
  localparam int          HALF_PERIOD = 5;
  localparam int          RESET_CYCLES = 12;
  localparam int          RANDOM_ITEMS = 1325;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE_CYCLES = 20;

  // Register offsets and field masks, kept apart from the package so that an error in the
  // package constants shows up as a mismatch rather than being copied into the predictor.
  localparam logic [15:0] A_USBCMD    = 16'h0080;
  localparam logic [15:0] A_USBSTS    = 16'h0084;
  localparam logic [15:0] A_DNCTRL    = 16'h0094;
  localparam logic [15:0] A_CRCR_LO   = 16'h0098;
  localparam logic [15:0] A_CRCR_HI   = 16'h009C;
  localparam logic [15:0] A_DCBAAP_LO = 16'h00B0;
  localparam logic [15:0] A_DCBAAP_HI = 16'h00B4;
  localparam logic [15:0] A_PORT_LO   = 16'h0480;
  localparam logic [15:0] A_PORT_HI   = 16'h0500;
  localparam logic [15:0] A_INTR_LO   = 16'h2020;
  localparam logic [15:0] A_INTR_HI   = 16'h2120;
  localparam logic [15:0] A_DB_LO     = 16'h3000;
  localparam logic [15:0] A_DB_HI     = 16'h3400;
  localparam logic [15:0] A_EXT_LO    = 16'h8000;
  localparam logic [15:0] A_EXT_HI    = 16'h8380;

  localparam logic [31:0] RW_USBCMD  = 32'h0001EF8C;
  localparam logic [31:0] CLR_USBSTS = 32'h0000041C;
  localparam logic [31:0] RW_LOW16   = 32'h0000FFFF;
  localparam logic [31:0] RW_CRCR    = 32'hFFFFFFC1;
  localparam logic [31:0] SET_CRCR   = 32'h00000006;
  localparam logic [31:0] RW_PTR     = 32'hFFFFFFC0;
  localparam logic [31:0] RW_PORTSC  = 32'h0E01C3E0;
  localparam logic [31:0] CLR_PORTSC = 32'h00FE0002;
  localparam logic [31:0] SET_PORTSC = 32'h80000010;
  localparam logic [31:0] RW_PM_LOW  = 32'hF001FFF8;
  localparam logic [31:0] RW_PM_HIGH = 32'h0001FFFF;
  localparam logic [31:0] RW_HLPMC   = 32'h00003FFF;
  localparam logic [31:0] RW_IMAN    = 32'h00000002;
  localparam logic [31:0] CLR_IMAN   = 32'h00000001;

  // One bus access as it is offered on the request channel.
  typedef struct packed {
    req_type_t   kind;
    logic [15:0] offset;
    logic        wide;
    logic [63:0] data;
  } access_t;

  // One row of the directed table. Where typed is set, the single result of the access is
  // taken from the row itself; otherwise the predictor supplies it.
  typedef struct packed {
    access_t     acc;
    logic        typed;
    logic [63:0] exp_read;
    event_code_t exp_code;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  uhrf_req_if req_ch ();
  uhrf_rsp_if rsp_ch ();

  usb_host_register_file_unit #(
    .STORE_WORDS(WORDS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mirror of the register store. A word is only ever read back, or merged by a masked
  // write, once it has been written, since the store holds no defined value before that.
  logic [31:0]   register_image [WORDS];
  bit            word_written   [WORDS];
  uhrf_result_t  awaited_results [$];
  int            mismatches;
  bit            hold_rsp_req;
  longint        cycle_count;

  logic [15:0] core_offs [0:6] = '{A_USBCMD, A_USBSTS, A_DNCTRL, A_CRCR_LO, A_CRCR_HI,
                                   A_DCBAAP_LO, A_DCBAAP_HI};
  // Offsets either side of each decoded range, by some core registers, and window ends.
  logic [15:0] boundary_offs [0:12] = '{16'h0000, 16'h007C, 16'h0088, 16'h00A0, 16'h047C,
                                        16'h0500, 16'h201C, 16'h2120, 16'h2FFC, 16'h3400,
                                        16'h7FFC, 16'h8380, 16'hFFFC};

  row_t directed_rows [0:24];

  function automatic logic [31:0] word_at(int unsigned w);
    return (w < WORDS) ? register_image[w] : 32'h0;
  endfunction

  // Words past the end of the store read as zero, so they count as known.
  function automatic bit word_known(int unsigned w);
    return (w >= WORDS) ? 1'b1 : word_written[w];
  endfunction

  function automatic void store_word(int unsigned w, logic [31:0] v);
    if (w < WORDS) begin
      register_image[w] = v;
      word_written[w]   = 1'b1;
    end
  endfunction

  // Read-write bits are copied, write-1-to-clear and write-1-to-set bits act where a one
  // is written, and everything else keeps its old value.
  function automatic logic [31:0] apply_write(logic [31:0] old, logic [31:0] nv,
                                              logic [31:0] rw, logic [31:0] clr,
                                              logic [31:0] set);
    logic [31:0] r;
    r = (old & ~rw) | (nv & rw);
    r = r & ~(nv & clr);
    return r | (nv & set);
  endfunction

  function automatic uhrf_result_t outcome(logic [63:0] rd, event_code_t code,
                                           logic [7:0] idx, logic [7:0] ep,
                                           logic [15:0] sid);
    uhrf_result_t r;
    r.read_data   = rd;
    r.ev.code     = code;
    r.ev.index    = idx;
    r.ev.endpoint = ep;
    r.ev.stream   = sid;
    r.last        = 1'b0;
    return r;
  endfunction

  // True where a masked write merges with the stored word, so the word must be known.
  function automatic bit merges_old(logic [15:0] off, logic wide);
    int  sub;
    bit  in_intr;
    in_intr = (off >= A_INTR_LO) && (off < A_INTR_HI);
    sub     = ((off - A_INTR_LO) >> 2) & 7;
    if (wide) begin
      return (off == A_CRCR_LO) || (off == A_DCBAAP_LO) || (in_intr && (sub == 4 || sub == 6));
    end
    return (off == A_USBCMD) || (off == A_USBSTS) || (off == A_DNCTRL) || (off == A_CRCR_LO) ||
           (off == A_DCBAAP_LO) || ((off >= A_PORT_LO) && (off < A_PORT_HI)) ||
           (in_intr && (sub == 0 || sub == 2 || sub == 4 || sub == 6));
  endfunction

  // Works out the results of one accepted access and updates the mirror. With keep clear
  // only the mirror is updated, for rows whose result is typed into the table.
  task automatic predict_access(input access_t a, input bit keep);
    logic [15:0]  off;
    logic [15:0]  rel;
    int unsigned  w;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  old;
    logic [63:0]  rd;
    int           sub;
    int           unit;
    bit           hit;
    uhrf_result_t made [$];
    off = a.offset & 16'hFFFC;
    w   = off >> 2;
    lo  = a.data[31:0];
    hi  = a.data[63:32];
    old = word_at(w);
    case (a.kind)
      REQ_READ: begin
        rd = {32'h0, old};
        if (a.wide) rd[63:32] = word_at(w + 1);
        made = {made, outcome(rd, EV_NONE, 8'h0, 8'h0, 16'h0)};
      end
      REQ_PRELOAD: begin
        store_word(w, lo);
        if (a.wide) store_word(w + 1, hi);
        made = {made, outcome(64'h0, EV_NONE, 8'h0, 8'h0, 16'h0)};
      end
      REQ_WRITE: begin
        if (!a.wide) begin
          if (off == A_USBCMD) begin
            // Run/stop and host reset only raise events; bits 0 and 1 stay as stored.
            if (!old[0] && lo[0]) begin
              made = {made, outcome(64'h0, EV_RUN, 8'h0, 8'h0, 16'h0)};
            end else if (old[0] && !lo[0]) begin
              made = {made, outcome(64'h0, EV_STOP, 8'h0, 8'h0, 16'h0)};
            end
            if (!old[1] && lo[1]) begin
              made = {made, outcome(64'h0, EV_HOST_RESET, 8'h0, 8'h0, 16'h0)};
            end
            store_word(w, apply_write(old, lo, RW_USBCMD, 32'h0, 32'h0));
          end else if (off == A_USBSTS) begin
            store_word(w, apply_write(old, lo, 32'h0, CLR_USBSTS, 32'h0));
          end else if (off == A_DNCTRL) begin
            store_word(w, apply_write(old, lo, RW_LOW16, 32'h0, 32'h0));
          end else if (off == A_CRCR_LO) begin
            store_word(w, apply_write(old, lo, RW_CRCR, 32'h0, SET_CRCR));
          end else if (off == A_CRCR_HI || off == A_DCBAAP_HI) begin
            store_word(w, lo);
          end else if (off == A_DCBAAP_LO) begin
            store_word(w, apply_write(old, lo, RW_PTR, 32'h0, 32'h0));
          end else if (off >= A_PORT_LO && off < A_PORT_HI) begin
            rel  = off - A_PORT_LO;
            unit = (rel >> 4) & 15;
            sub  = (rel >> 2) & 3;
            case (sub)
              0: begin
                if (lo[4]) made = {made, outcome(64'h0, EV_PORT_RESET, 8'(unit), 8'h0, 16'h0)};
                store_word(w, apply_write(old, lo, RW_PORTSC, CLR_PORTSC, SET_PORTSC));
              end
              1: store_word(w, apply_write(old, lo, (unit < 4) ? RW_PM_LOW : RW_PM_HIGH,
                                           32'h0, 32'h0));
              2: store_word(w, apply_write(old, lo, RW_LOW16, 32'h0, 32'h0));
              default: store_word(w, apply_write(old, lo, RW_HLPMC, 32'h0, 32'h0));
            endcase
          end else if (off >= A_INTR_LO && off < A_INTR_HI) begin
            rel  = off - A_INTR_LO;
            sub  = (rel >> 2) & 7;
            unit = rel >> 5;
            if (sub == 0) begin
              if (!old[1] && lo[1]) begin
                made = {made, outcome(64'h0, EV_INTR_ENABLE, 8'(unit), 8'h0, 16'h0)};
              end
              store_word(w, apply_write(old, lo, RW_IMAN, CLR_IMAN, 32'h0));
            end else if (sub == 2) begin
              store_word(w, apply_write(old, lo, RW_LOW16, 32'h0, 32'h0));
            end else if (sub == 4 || sub == 6) begin
              store_word(w, apply_write(old, lo, RW_PTR, 32'h0, 32'h0));
            end else if (sub != 3) begin
              store_word(w, lo);
            end
          end else if (off == A_DB_LO) begin
            made = {made, outcome(64'h0, EV_CMD_DB, 8'h0, 8'h0, 16'h0)};
          end else if (off > A_DB_LO && off < A_DB_HI) begin
            // The stream id is the whole upper half of the written word.
            made = {made, outcome(64'h0, EV_XFER_DB, 8'((off - A_DB_LO) >> 2), lo[7:0],
                                  lo[31:16])};
          end else if (off >= A_EXT_LO && off < A_EXT_HI) begin
            store_word(w, lo);
          end
          if (made.size() == 0) made = {made, outcome(64'h0, EV_NONE, 8'h0, 8'h0, 16'h0)};
        end else begin
          // Wide masked writes are decoded only for the 64-bit pointer registers.
          hit = 1'b0;
          sub = ((off - A_INTR_LO) >> 2) & 7;
          if (off == A_CRCR_LO) begin
            store_word(w, apply_write(old, lo, RW_CRCR, 32'h0, SET_CRCR));
            hit = 1'b1;
          end else if (off == A_DCBAAP_LO ||
                       (off >= A_INTR_LO && off < A_INTR_HI && (sub == 4 || sub == 6))) begin
            store_word(w, apply_write(old, lo, RW_PTR, 32'h0, 32'h0));
            hit = 1'b1;
          end
          if (hit) store_word(w + 1, hi);
          made = {made, outcome(64'h0, EV_NONE, 8'h0, 8'h0, 16'h0)};
        end
      end
      default: begin
        made = {made, outcome(64'h0, EV_NONE, 8'h0, 8'h0, 16'h0)};
      end
    endcase
    made[made.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (made[i]) awaited_results = {awaited_results, made[i]};
    end
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random access weighted towards the decoded registers. Anything that would read or
  // merge with a word not yet written is turned into a preload of that word instead.
  function automatic access_t draw_access();
    access_t     a;
    int          pick;
    int unsigned w;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      a.kind = REQ_NONE;
    end else if (pick < 25) begin
      a.kind = REQ_PRELOAD;
    end else if (pick < 55) begin
      a.kind = REQ_READ;
    end else begin
      a.kind = REQ_WRITE;
    end
    case ($urandom_range(0, 9))
      0, 9:    a.offset = core_offs[$urandom_range(0, 6)];
      1, 2:    a.offset = A_PORT_LO + 16'($urandom_range(0, 31) * 4);
      3, 4:    a.offset = A_INTR_LO + 16'($urandom_range(0, 63) * 4);
      5:       a.offset = A_DB_LO + 16'($urandom_range(0, 255) * 4);
      6:       a.offset = A_EXT_LO + 16'($urandom_range(0, 223) * 4);
      7:       a.offset = 16'($urandom) & 16'hFFFC;
      default: a.offset = boundary_offs[$urandom_range(0, 12)];
    endcase
    // The low two offset bits are meant to be ignored, so they are stirred now and then.
    if ($urandom_range(0, 3) == 0) a.offset[1:0] = 2'($urandom);
    a.wide = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 15))
      0:       a.data = 64'h0;
      1:       a.data = '1;
      default: a.data = {$urandom, $urandom};
    endcase
    w = a.offset >> 2;
    if (a.kind == REQ_READ && !(word_known(w) && (!a.wide || word_known(w + 1)))) begin
      a.kind = REQ_PRELOAD;
    end
    if (a.kind == REQ_WRITE && merges_old(a.offset & 16'hFFFC, a.wide) && !word_known(w)) begin
      a.kind = REQ_PRELOAD;
    end
    return a;
  endfunction

  // Offers one access after the given idle gap and returns at the edge where it is taken.
  // With no gap, valid simply stays high from the previous transaction.
  task automatic send(input access_t a, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= a.kind;
    req_ch.byte_offset <= a.offset;
    req_ch.wide_access <= a.wide;
    req_ch.write_data  <= a.data;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_result();
    uhrf_result_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result transaction arrived with nothing pending");
    end else begin
      want = awaited_results.pop_front();
      check_field("read_data", want.read_data, rsp_ch.read_data);
      check_field("event_code", 64'(want.ev.code), 64'(rsp_ch.event_code));
      check_field("event_index", 64'(want.ev.index), 64'(rsp_ch.event_index));
      check_field("endpoint_id", 64'(want.ev.endpoint), 64'(rsp_ch.endpoint_id));
      check_field("stream_num", 64'(want.ev.stream), 64'(rsp_ch.stream_num));
      check_field("last_result", 64'(want.last), 64'(rsp_ch.last_result));
    end
  endtask

  // Result side: checks every transaction taken at a rising edge, then decides ready for
  // the next cycle. Open stretches of varying length alternate with stalls; a request
  // from the stimulus process turns into one long hold-off, counted here.
  initial begin
    int stall_left;
    int open_left;
    stall_left = 0;
    open_left  = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        stall_left   = 400;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (open_left > 0) begin
          open_left--;
        end else begin
          open_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 10);
          stall_left = idle_len();
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then the random part, then the drain and the verdict.
  initial begin
    access_t      acc;
    uhrf_result_t typed_res;
    int           gap;
    mismatches   = 0;
    hold_rsp_req = 1'b0;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_NONE;
    req_ch.byte_offset <= 16'h0;
    req_ch.wide_access <= 1'b0;
    req_ch.write_data  <= 64'h0;

    // Directed rows. The command register is preloaded with run set so that the first
    // write sees a stop edge together with a host reset, then cleared to see a run edge.
    // Port 7 is reached through an unaligned offset, the last doorbell slot carries a
    // full stream id, and the top word of the window is read wide so that the second
    // word falls beyond the store and must read as zero.
    directed_rows = '{
      '{'{REQ_PRELOAD, 16'h0080, 1'b0, 64'h0000000000000001}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h0084, 1'b0, 64'h00000000FFFFFFFF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h0094, 1'b1, 64'hFFFFFFFF00000000}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h00B0, 1'b1, 64'h0123456789ABCDEF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_READ,    16'h00B0, 1'b1, 64'h0},
        1'b1, 64'h0123456789ABCDEF, EV_NONE},
      '{'{REQ_WRITE,   16'h0080, 1'b0, 64'h00000000FFFFFFFE}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h0080, 1'b0, 64'h0},                1'b1, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h0080, 1'b0, 64'h0000000000000001}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_READ,    16'h0080, 1'b0, 64'h0},                1'b0, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h0084, 1'b0, 64'hFFFFFFFFFFFFFFFF}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h0098, 1'b1, 64'hFFFFFFFFFFFFFFFF}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_READ,    16'h0098, 1'b1, 64'h0},                1'b0, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h0480, 1'b1, 64'h0},                1'b1, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h0480, 1'b0, 64'h0000000000000010}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h04F0, 1'b0, 64'h00000000FFFFFFFF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h04F3, 1'b0, 64'h00000000FFFFFFFF}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'h2020, 1'b1, 64'h0},                1'b1, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h2020, 1'b0, 64'h0000000000000003}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h3000, 1'b0, 64'h00000000FFFFFFFF}, 1'b1, 64'h0, EV_CMD_DB},
      '{'{REQ_WRITE,   16'h33FC, 1'b0, 64'h00000000ABCD00EF}, 1'b0, 64'h0, EV_NONE},
      '{'{REQ_WRITE,   16'h0100, 1'b0, 64'h00000000FFFFFFFF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_NONE,    16'hFFFF, 1'b1, 64'hFFFFFFFFFFFFFFFF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_PRELOAD, 16'hFFFC, 1'b1, 64'hFFFFFFFFFFFFFFFF}, 1'b1, 64'h0, EV_NONE},
      '{'{REQ_READ,    16'hFFFC, 1'b1, 64'h0},
        1'b1, 64'h00000000FFFFFFFF, EV_NONE},
      '{'{REQ_WRITE,   16'h837C, 1'b0, 64'h000000005A5AA5A5}, 1'b0, 64'h0, EV_NONE}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      acc = directed_rows[i].acc;
      send(acc, idle_len());
      if (directed_rows[i].typed) begin
        predict_access(acc, 1'b0);
        typed_res      = outcome(directed_rows[i].exp_read, directed_rows[i].exp_code,
                                 8'h0, 8'h0, 16'h0);
        typed_res.last = 1'b1;
        awaited_results = {awaited_results, typed_res};
      end else begin
        predict_access(acc, 1'b1);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Part way through, the result side holds off for a long stretch while requests
      // keep coming, so that the holding register fills and the input stalls.
      if (n == 500) hold_rsp_req = 1'b1;
      // Later on the request side stops until every pending result has been returned.
      if (n == 900) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
      end
      // Every fifth stretch of transactions runs back to back with no gaps.
      gap = (((n / 120) % 5) == 4) ? 0 : idle_len();
      acc = draw_access();
      send(acc, gap);
      predict_access(acc, 1'b1);
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // The settle wait lets any stray result transaction still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
